// ===== src/olid_pkg.sv =====
`timescale 1ns / 1ps

package olid_pkg;

  // Fixed field widths of the item and result channels.
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int OP_W    = 3;
  localparam int OUT_N_W = 7;
  localparam int STAT_W  = 2;

  // Operation codes carried in the opcode field.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } opcode_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic rd_issue;  // read one memory entry into the read register
    logic wr_shift;  // write the read register one place over and step the pointer
    logic commit;    // apply the operation and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shift_more;  // another entry must move before the operation completes
    logic need_read;   // a read operation at a valid position
  } sts_t;

endpackage

// ===== src/olid_in_if.sv =====
`timescale 1ns / 1ps

interface olid_in_if;
  import olid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output opcode, output position, output data_value,
                  input ready);
  modport sink (input valid, input opcode, input position, input data_value,
                output ready);
endinterface

// ===== src/olid_out_if.sv =====
`timescale 1ns / 1ps

interface olid_out_if;
  import olid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [OUT_N_W-1:0]       used_count;
  logic [OUT_N_W-1:0]       capacity;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output read_value, output used_count, output capacity,
                  output status, input ready);
  modport sink (input valid, input read_value, input used_count, input capacity,
                input status, output ready);
endinterface

// ===== src/olid_datapath.sv =====
`timescale 1ns / 1ps

module olid_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  olid_pkg::cmd_t                    cmd,
  output olid_pkg::sts_t                    sts,
  input  logic [olid_pkg::OP_W-1:0]         opcode,
  input  logic [olid_pkg::POS_W-1:0]        position,
  input  logic signed [olid_pkg::DATA_W-1:0] data_value,
  output logic signed [olid_pkg::DATA_W-1:0] read_value,
  output logic [olid_pkg::OUT_N_W-1:0]      used_count,
  output logic [olid_pkg::OUT_N_W-1:0]      capacity,
  output logic [olid_pkg::STAT_W-1:0]       status
);
  import olid_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // Entry storage: one write and one registered read per cycle.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  // Latched item and architectural state.
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] word;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cap;
  logic [CW-1:0]     ptr;

  // Result register.
  logic [DATA_W-1:0]  res_value;
  logic [OUT_N_W-1:0] res_count;
  logic [OUT_N_W-1:0] res_cap;
  logic [STAT_W-1:0]  res_status;

  logic          is_ins, is_del, pos_ok, full, more_ins, more_del;
  logic [XW-1:0] pos_x, cnt_x, ptr_x;
  logic [CW-1:0] rd_ptr, cap_grow, cap_half, cnt_less;
  logic [CW-1:0] count_next, cap_next;
  logic [CW-1:0] ptr_next;
  logic [DATA_W-1:0] value_next;
  logic [STAT_W-1:0] status_next;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Position checks and shift progress.
  always_comb begin
    pos_x    = XW'(pos);
    cnt_x    = XW'(count);
    ptr_x    = XW'(ptr);
    is_ins   = (op == OP_INSERT);
    is_del   = (op == OP_DELETE);
    pos_ok   = (pos_x < cnt_x);
    full     = (count >= CW'(DEPTH));
    more_ins = (ptr_x > pos_x);
    more_del = ((ptr + CW'(1)) < count);
    sts.shift_more = (is_ins && pos_ok && !full && more_ins) || (is_del && pos_ok && more_del);
    sts.need_read  = (op == OP_READ) && pos_ok;
    if (is_ins) begin
      rd_ptr = ptr - CW'(1);
    end else if (is_del) begin
      rd_ptr = ptr + CW'(1);
    end else begin
      rd_ptr = CW'(pos);
    end
  end

  // Capacity doubling and halving.
  always_comb begin
    cap_grow = (count >= cap) ? (cap << 1) : cap;
    cap_half = (cap >> 1);
    cnt_less = (count == '0) ? count : (count - CW'(1));
  end

  // Outcome of the latched operation at commit.
  always_comb begin
    count_next  = count;
    cap_next    = cap;
    value_next  = '0;
    status_next = ST_DONE;
    wr_en       = 1'b0;
    wr_addr     = ptr[AW-1:0];
    wr_data     = rdata;
    if (cmd.wr_shift) begin
      wr_en = 1'b1;
    end
    if (cmd.commit) begin
      unique case (op)
        OP_PUSH: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            cap_next   = cap_grow;
            count_next = count + CW'(1);
            wr_en      = 1'b1;
            wr_addr    = count[AW-1:0];
            wr_data    = word;
          end
        end
        OP_POP: begin
          count_next = cnt_less;
          if (cnt_less <= cap_half) begin
            cap_next = (cap_half == '0) ? CW'(1) : cap_half;
          end
        end
        OP_INSERT: begin
          if (!pos_ok) begin
            status_next = ST_BADPOS;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            cap_next   = cap_grow;
            count_next = count + CW'(1);
            wr_en      = 1'b1;
            wr_addr    = AW'(pos);
            wr_data    = word;
          end
        end
        OP_DELETE: begin
          if (!pos_ok) begin
            status_next = ST_BADPOS;
          end else begin
            count_next = cnt_less;
            if (cnt_less <= cap_half) begin
              cap_next = (cap_half == '0) ? CW'(1) : cap_half;
            end
          end
        end
        OP_READ: begin
          if (pos_ok) begin
            value_next = rdata;
          end else begin
            value_next  = '1;
            status_next = ST_BADPOS;
          end
        end
        OP_CLEAR: begin
          count_next = '0;
          cap_next   = CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Shift pointer: insert walks down from the end, delete walks up from the position.
  always_comb begin
    ptr_next = ptr;
    if (cmd.capture) begin
      ptr_next = (opcode == OP_INSERT) ? count : CW'(position);
    end else if (cmd.wr_shift) begin
      ptr_next = is_ins ? (ptr - CW'(1)) : (ptr + CW'(1));
    end
  end

  // Memory port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[rd_ptr[AW-1:0]];
    end
  end

  // Item latch, pointer and result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= opcode;
      pos  <= position;
      word <= data_value;
    end
    ptr <= ptr_next;
    if (cmd.commit) begin
      res_value  <= value_next;
      res_count  <= OUT_N_W'(count_next);
      res_cap    <= OUT_N_W'(cap_next);
      res_status <= status_next;
    end
  end

  // Entry count and nominal capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CW'(1);
    end else begin
      count <= count_next;
      cap   <= cap_next;
    end
  end

  assign read_value = res_value;
  assign used_count = res_count;
  assign capacity   = res_cap;
  assign status     = res_status;

  // The count never passes the storage depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  // The nominal capacity is always a single power of two.
  a_cap_pow2: assert property (@(posedge clk) disable iff (rst)
    $onehot(cap))
    else $error("capacity not a power of two");

  // Count and capacity change only when an operation commits.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(count) && $stable(cap))
    else $error("count or capacity changed without a commit");

endmodule

// ===== src/olid_ctrl.sv =====
`timescale 1ns / 1ps

module olid_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  olid_pkg::sts_t sts,
  output olid_pkg::cmd_t cmd
);
  import olid_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Commands follow the current state and datapath status.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_DECIDE: begin
        cmd.rd_issue = sts.shift_more || sts.need_read;
      end
      S_SHIFT: begin
        cmd.wr_shift = 1'b1;
      end
      S_FINISH: begin
        cmd.commit = out_free;
      end
      default: begin
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (sts.shift_more) begin
            state <= S_SHIFT;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SHIFT: begin
          state <= S_DECIDE;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> out_free)
    else $error("result overwritten before it was taken");

  // A committed result is offered in the following cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not offered");

  // Memory reads and write phases (commit or shift write) fall in different cycles.
  a_rd_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_issue && (cmd.commit || cmd.wr_shift)))
    else $error("memory read overlaps a write phase");

endmodule

// ===== src/ordered_list_insert_delete.sv =====
`timescale 1ns / 1ps

// Ordered store of up to DEPTH signed 32-bit words with push, pop, insert,
// delete, read and clear, one result item per input item. Entries live in a
// single-port memory with a registered read, so insert and delete move the
// later entries one at a time, each entry read in the decide state and
// written one place over in the shift state. Every item passes from idle
// through decide and finish back to idle; an insert that is carried out at
// position p goes through shift count - p times and a delete that is
// carried out at position p goes through shift count - p - 1 times.
// A new item is taken while the previous result still waits at the output;
// the block only holds off at the end of an operation if that result has not
// been taken yet. Storage needs no clearing after reset: entries at or above
// the count are never read.
module ordered_list_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  olid_in_if.sink    req,
  olid_out_if.source rsp
);
  import olid_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  olid_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (req.opcode),
    .position   (req.position),
    .data_value (req.data_value),
    .read_value (rsp.read_value),
    .used_count (rsp.used_count),
    .capacity   (rsp.capacity),
    .status     (rsp.status)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import olid_pkg::*;

  localparam int DEPTH       = 64;
  localparam int ITEM_TOTAL  = 1850;
  localparam int QUIET_TAIL  = 250;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 100;

  // Opcodes outside the defined set; the block must leave the store alone.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} phase_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] word;
  } list_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [OUT_N_W-1:0]       used_count;
    logic [OUT_N_W-1:0]       capacity;
    status_t                  status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  olid_in_if  req_if ();
  olid_out_if rsp_if ();

  ordered_list_insert_delete #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #6 clk = ~clk;

  // Shadow copy of the store.
  logic signed [DATA_W-1:0] list_words [DEPTH];
  int list_count = 0;
  int list_cap   = 1;

  // Both queues take new entries at the front and give up the oldest at the back.
  list_op_t     pending_ops [$];
  list_result_t expected_results [$];

  int plan_count     = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int reads_done     = 0;
  int full_refusals  = 0;
  int bad_positions  = 0;
  int peak_count     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;
  bit item_taken     = 1'b0;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, msg);
  endtask

  // Capacity doubles when a growing operation finds the store at capacity.
  function automatic void grow_capacity();
    if (list_count >= list_cap)
      list_cap = list_cap << 1;
  endfunction

  // Capacity halves once the store is at most half full, never below one.
  function automatic void shrink_capacity();
    if (list_count <= list_cap / 2)
      list_cap = (list_cap > 1) ? (list_cap >> 1) : 1;
  endfunction

  // Apply one operation to the shadow store and return the result it gives.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [DATA_W-1:0] word);
    list_result_t r;
    r.read_value = '0;
    r.status     = ST_DONE;
    case (op)
      OP_PUSH: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          grow_capacity();
          list_words[list_count] = word;
          list_count++;
        end
      end
      OP_POP: begin
        if (list_count > 0)
          list_count--;
        shrink_capacity();
      end
      OP_INSERT: begin
        if (pos >= list_count) begin
          r.status = ST_BADPOS;
        end else if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          grow_capacity();
          for (int i = list_count; i > pos; i--)
            list_words[i] = list_words[i-1];
          list_words[pos] = word;
          list_count++;
        end
      end
      OP_DELETE: begin
        if (pos >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = pos; i + 1 < list_count; i++)
            list_words[i] = list_words[i+1];
          list_count--;
          shrink_capacity();
        end
      end
      OP_READ: begin
        reads_done++;
        if (pos < list_count) begin
          r.read_value = list_words[pos];
        end else begin
          r.read_value = -1;
          r.status     = ST_BADPOS;
        end
      end
      OP_CLEAR: begin
        list_count = 0;
        list_cap   = 1;
      end
      default: ;
    endcase
    if (r.status == ST_FULL)
      full_refusals++;
    if (r.status == ST_BADPOS)
      bad_positions++;
    if (list_count > peak_count)
      peak_count = list_count;
    r.used_count = list_count[OUT_N_W-1:0];
    r.capacity   = list_cap[OUT_N_W-1:0];
    return r;
  endfunction

  // Queue one item and track the fill level so random positions stay mostly in range.
  task automatic queue_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] word);
    list_op_t it;
    it.op   = op;
    it.pos  = pos;
    it.word = word;
    pending_ops.push_front(it);
    case (op)
      OP_PUSH:   if (plan_count < DEPTH) plan_count++;
      OP_POP:    if (plan_count > 0) plan_count--;
      OP_INSERT: if (pos < plan_count && plan_count < DEPTH) plan_count++;
      OP_DELETE: if (pos < plan_count) plan_count--;
      OP_CLEAR:  plan_count = 0;
      default: ;
    endcase
  endtask

  // Stimulus, reset and end of run.
  initial begin
    phase_t phase;
    int seg_left;
    int pick;
    int t_push, t_pop, t_ins, t_del, t_rd, t_clr;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] word;

    rst                = 1'b1;
    req_if.valid      = 1'b0;
    req_if.opcode     = '0;
    req_if.position   = '0;
    req_if.data_value = '0;
    rsp_if.ready      = 1'b0;

    // Empty store: pop keeps capacity at one, positions are all invalid.
    queue_item(OP_POP, 0, 0);
    queue_item(OP_READ, 0, 0);
    queue_item(OP_DELETE, 0, 0);
    queue_item(OP_INSERT, 0, 32'sd5);
    // Extreme words, with the capacity doubling on the way.
    queue_item(OP_PUSH, 0, {1'b0, {31{1'b1}}});
    queue_item(OP_PUSH, 0, {1'b1, {31{1'b0}}});
    queue_item(OP_PUSH, 63, -1);
    queue_item(OP_PUSH, 0, 0);
    queue_item(OP_INSERT, 0, 32'sh12345678);
    // Insert at the count itself and far past it is refused.
    queue_item(OP_INSERT, 5, 32'sh0badf00d);
    queue_item(OP_INSERT, 63, -1);
    queue_item(OP_INSERT, 2, 32'sh5a5a5a5a);
    queue_item(OP_READ, 0, 0);
    queue_item(OP_READ, 5, 0);
    queue_item(OP_READ, 6, 0);
    queue_item(OP_READ, 63, -1);
    queue_item(OP_DELETE, 2, 0);
    queue_item(OP_DELETE, 4, 0);
    queue_item(OP_DELETE, 4, 0);
    queue_item(OP_SPARE_LO, 63, -1);
    queue_item(OP_SPARE_HI, 42, 32'sh2aaaaaaa);
    queue_item(OP_POP, 0, 0);
    queue_item(OP_CLEAR, 0, 0);
    queue_item(OP_PUSH, 0, 32'sd7);

    // Random part in phases that push the store toward full or empty.
    seg_left = 0;
    phase    = PHASE_GROW;
    while (pending_ops.size() < ITEM_TOTAL) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 90);
        phase    = phase_t'($urandom_range(0, 2));
      end
      seg_left--;
      case (phase)
        PHASE_GROW: begin
          t_push = 48; t_pop = 53; t_ins = 81; t_del = 87; t_rd = 98; t_clr = 98;
        end
        PHASE_SHRINK: begin
          t_push = 10; t_pop = 40; t_ins = 48; t_del = 82; t_rd = 96; t_clr = 98;
        end
        default: begin
          t_push = 22; t_pop = 38; t_ins = 56; t_del = 72; t_rd = 93; t_clr = 96;
        end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < t_push)     op = OP_PUSH;
      else if (pick < t_pop) op = OP_POP;
      else if (pick < t_ins) op = OP_INSERT;
      else if (pick < t_del) op = OP_DELETE;
      else if (pick < t_rd)  op = OP_READ;
      else if (pick < t_clr) op = OP_CLEAR;
      else                   op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;

      // Mostly positions in use, some at the boundary, some anywhere.
      case ($urandom_range(0, 9))
        0, 1:    pos = POS_W'($urandom_range(0, 63));
        2:       pos = (plan_count > 63) ? POS_W'(63) : POS_W'(plan_count);
        default: pos = (plan_count == 0) ? '0 : POS_W'($urandom_range(0, plan_count - 1));
      endcase

      case ($urandom_range(0, 11))
        0:       word = {1'b0, {31{1'b1}}};
        1:       word = {1'b1, {31{1'b0}}};
        2:       word = -1;
        3:       word = 0;
        default: word = $urandom;
      endcase
      queue_item(op, pos, word);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_ops.size() > 0 || req_if.valid)
      @(posedge clk);
    while (expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d items through the store: %0d reads, %0d invalid positions,",
             items_accepted, reads_done, bad_positions);
    $display("%0d refusals at full, peak fill %0d of %0d, %0d results checked.",
             full_refusals, peak_count, DEPTH, results_seen);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Input side: predict each accepted item.
  always @(posedge clk) begin
    list_result_t pred;
    if (!rst && req_if.valid && req_if.ready) begin
      pred = apply_list_op(req_if.opcode, req_if.position, req_if.data_value);
      expected_results.push_front(pred);
      items_accepted++;
      item_taken = 1'b1;
    end
  end

  // Sender: holds an item until taken, with random idle bursts before the tail.
  always @(negedge clk) begin
    list_op_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || item_taken) begin
      if (gap_left == 0 && pending_ops.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
        gap_left = $urandom_range(1, 10);
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        nxt = pending_ops.pop_back();
        req_if.opcode     <= nxt.op;
        req_if.position   <= nxt.pos;
        req_if.data_value <= nxt.word;
        req_if.valid      <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  // Receiver: short random stalls, plus one long hold-off that backs up the block.
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      rsp_if.ready  <= 1'b0;
    end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      hold_left     = $urandom_range(0, 9);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Output side: compare each result with the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = expected_results.pop_back();
        if (rsp_if.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %0d, expected %0d",
                                    rsp_if.read_value, want.read_value));
        if (rsp_if.used_count !== want.used_count)
          report_mismatch($sformatf("used_count %0d, expected %0d",
                                    rsp_if.used_count, want.used_count));
        if (rsp_if.capacity !== want.capacity)
          report_mismatch($sformatf("capacity %0d, expected %0d",
                                    rsp_if.capacity, want.capacity));
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    rsp_if.status, want.status));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d items queued, %0d results outstanding",
               cycle_count, pending_ops.size(), expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
